// ----- rtl/aabb_pkg.sv -----
`default_nettype none

package aabb_pkg;

    localparam int COORD_W  = 32;
    localparam int HALF_W   = 31;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int FRAC_W   = 16;
    localparam int TERM_W   = PROD_W - FRAC_W;
    localparam int SUM_W    = TERM_W + 2;
    localparam int AXES     = 3;
    localparam int COLS     = 4;
    localparam int NUM_REGS = 6;
    localparam int IDX_W    = 3;
    localparam int CFG_W    = 64;
    localparam int PAD_W    = 3;
    localparam int IN_W     = 2 * AXES * COORD_W;
    localparam int OUT_W    = 3 * AXES * COORD_W + AXES * HALF_W + PAD_W;

    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef logic [NUM_REGS-1:0][CFG_W-1:0] mat_t;

    // identity after reset
    localparam mat_t MAT_RESET = {
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    // lo corner in the low half, x lowest
    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] hi;
        logic [AXES-1:0][COORD_W-1:0] lo;
    } box_t;

    // [row][col] products already shifted down by FRAC_W
    typedef struct packed {
        logic [AXES-1:0][AXES-1:0][TERM_W-1:0] hi;
        logic [AXES-1:0][AXES-1:0][TERM_W-1:0] lo;
    } terms_t;

    typedef struct packed {
        logic [AXES-1:0][AXES-1:0][TERM_W-1:0] tmax;
        logic [AXES-1:0][AXES-1:0][TERM_W-1:0] tmin;
    } sel_t;

    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] bmax;
        logic [AXES-1:0][COORD_W-1:0] bmin;
    } bounds_t;

    typedef struct packed {
        logic [PAD_W-1:0]             pad;
        logic [AXES-1:0][HALF_W-1:0]  half;
        logic [AXES-1:0][COORD_W-1:0] ctr;
        logic [AXES-1:0][COORD_W-1:0] bmax;
        logic [AXES-1:0][COORD_W-1:0] bmin;
    } out_t;

    function automatic logic signed [COORD_W-1:0] mat_entry(mat_t m, int r, int c);
        logic [CFG_W-1:0] pair;
        pair = m[r * 2 + (c >> 1)];
        if (c % 2 == 1)
            return $signed(pair[COORD_W-1:0]);
        else
            return $signed(pair[CFG_W-1:COORD_W]);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/aabb_mul.sv -----
`default_nettype none

module aabb_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  aabb_pkg::mat_t   mat,
    input  logic            in_valid,
    output logic            in_ready,
    input  aabb_pkg::box_t   box,
    output logic            out_valid,
    input  logic            out_ready,
    output aabb_pkg::terms_t terms
);
    import aabb_pkg::*;

    logic   valid_reg;
    terms_t terms_reg;
    terms_t terms_next;
    logic   load;

    logic signed [PROD_W-1:0] prod_lo [AXES][AXES];
    logic signed [PROD_W-1:0] prod_hi [AXES][AXES];

    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                prod_lo[r][c] = mat_entry(mat, r, c) * $signed(box.lo[c]);
                prod_hi[r][c] = mat_entry(mat, r, c) * $signed(box.hi[c]);
                terms_next.lo[r][c] = prod_lo[r][c][PROD_W-1:FRAC_W];
                terms_next.hi[r][c] = prod_hi[r][c][PROD_W-1:FRAC_W];
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign terms     = terms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            terms_reg <= terms_next;
    end

endmodule

`default_nettype wire

// ----- rtl/aabb_sel.sv -----
`default_nettype none

module aabb_sel (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  aabb_pkg::terms_t terms,
    output logic             out_valid,
    input  logic             out_ready,
    output aabb_pkg::sel_t   sel
);
    import aabb_pkg::*;

    logic valid_reg;
    sel_t sel_reg;
    sel_t sel_next;
    logic load;

    // each term depends on one coordinate only, so min/max split per term
    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                if ($signed(terms.lo[r][c]) < $signed(terms.hi[r][c]))
                begin
                    sel_next.tmin[r][c] = terms.lo[r][c];
                    sel_next.tmax[r][c] = terms.hi[r][c];
                end
                else
                begin
                    sel_next.tmin[r][c] = terms.hi[r][c];
                    sel_next.tmax[r][c] = terms.lo[r][c];
                end
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign sel       = sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            sel_reg <= sel_next;
    end

endmodule

`default_nettype wire

// ----- rtl/aabb_sum.sv -----
`default_nettype none

module aabb_sum (
    input  logic              clk,
    input  logic              rst_n,
    input  aabb_pkg::mat_t    mat,
    input  logic              in_valid,
    output logic              in_ready,
    input  aabb_pkg::sel_t    sel,
    output logic              out_valid,
    input  logic              out_ready,
    output aabb_pkg::bounds_t bounds
);
    import aabb_pkg::*;

    logic    valid_reg;
    bounds_t bounds_reg;
    bounds_t bounds_next;
    logic    load;

    logic signed [SUM_W-1:0] sum_min [AXES];
    logic signed [SUM_W-1:0] sum_max [AXES];

    function automatic logic [COORD_W-1:0] sat32(logic signed [SUM_W-1:0] v);
        if (&v[SUM_W-1:COORD_W-1] || ~|v[SUM_W-1:COORD_W-1])
            return v[COORD_W-1:0];
        else if (v[SUM_W-1])
            return COORD_MIN;
        else
            return COORD_MAX;
    endfunction

    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            sum_min[r] = SUM_W'(mat_entry(mat, r, COLS - 1));
            sum_max[r] = SUM_W'(mat_entry(mat, r, COLS - 1));
            for (int c = 0; c < AXES; c++)
            begin
                sum_min[r] = sum_min[r] + SUM_W'($signed(sel.tmin[r][c]));
                sum_max[r] = sum_max[r] + SUM_W'($signed(sel.tmax[r][c]));
            end
            bounds_next.bmin[r] = sat32(sum_min[r]);
            bounds_next.bmax[r] = sat32(sum_max[r]);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign bounds    = bounds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            bounds_reg <= bounds_next;
    end

endmodule

`default_nettype wire

// ----- rtl/aabb_fin.sv -----
`default_nettype none

module aabb_fin (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  aabb_pkg::bounds_t bounds,
    output logic              out_valid,
    input  logic              out_ready,
    output aabb_pkg::out_t    res
);
    import aabb_pkg::*;

    logic valid_reg;
    out_t res_reg;
    out_t res_next;
    logic load;

    logic signed [COORD_W:0] ctr_sum [AXES];
    logic signed [COORD_W:0] ext_diff [AXES];

    always_comb
    begin
        res_next.pad  = '0;
        res_next.bmin = bounds.bmin;
        res_next.bmax = bounds.bmax;
        for (int a = 0; a < AXES; a++)
        begin
            ctr_sum[a]  = (COORD_W+1)'($signed(bounds.bmax[a]))
                        + (COORD_W+1)'($signed(bounds.bmin[a]));
            ext_diff[a] = (COORD_W+1)'($signed(bounds.bmax[a]))
                        - (COORD_W+1)'($signed(bounds.bmin[a]));
            res_next.ctr[a]  = ctr_sum[a][COORD_W:1];
            res_next.half[a] = ext_diff[a][HALF_W:1];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

endmodule

`default_nettype wire

// ----- rtl/aabb_affine_transform_top.sv -----
`default_nettype none

// Transforms an axis-aligned box (Q16.16) by a 3x4 affine matrix and returns the
// bounding box of the eight transformed corners with its center and half extent.
// Four register stages (multiply, per-term min/max select, sum and saturate,
// center/extent); a box is accepted every cycle unless an output stall backs up the
// pipeline, and its result passes through the stage registers in order to m_tdata,
// where it is held while the output stalls. Each stage holds its item under
// backpressure, so bubbles are squeezed out. The matrix sits in six 64-bit registers
// written through cfg_we/cfg_index/cfg_data, reset to identity; write them only
// while the pipeline is empty. Indexes above five are ignored.
module aabb_affine_transform_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [aabb_pkg::IDX_W-1:0]   cfg_index,
    input  logic [aabb_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [aabb_pkg::IN_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_min_x/y/z, out_max_x/y/z, center_x/y/z, half_extent_x/y/z, 3 zero bits
    output logic [aabb_pkg::OUT_W-1:0]   m_tdata
);
    import aabb_pkg::*;

    mat_t    mat_reg;
    box_t    box;
    terms_t  terms;
    sel_t    sel;
    bounds_t bounds;
    out_t    res;

    logic mul_valid;
    logic sel_ready;
    logic sel_valid;
    logic sum_ready;
    logic sum_valid;
    logic fin_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mat_reg <= MAT_RESET;
        else if (cfg_we && (cfg_index < IDX_W'(NUM_REGS)))
            mat_reg[cfg_index] <= cfg_data;
    end

    assign box     = s_tdata;
    assign m_tdata = res;

    aabb_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat       (mat_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .box       (box),
        .out_valid (mul_valid),
        .out_ready (sel_ready),
        .terms     (terms)
    );

    aabb_sel u_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (sel_ready),
        .terms     (terms),
        .out_valid (sel_valid),
        .out_ready (sum_ready),
        .sel       (sel)
    );

    aabb_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat       (mat_reg),
        .in_valid  (sel_valid),
        .in_ready  (sum_ready),
        .sel       (sel),
        .out_valid (sum_valid),
        .out_ready (fin_ready),
        .bounds    (bounds)
    );

    aabb_fin u_fin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (fin_ready),
        .bounds    (bounds),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res)
    );

`ifndef NO_ASSERTIONS
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> mul_valid)
        else $error("accepted box did not enter the multiply stage");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(res.bmin[0]) <= $signed(res.bmax[0]))
                  && ($signed(res.bmin[1]) <= $signed(res.bmax[1]))
                  && ($signed(res.bmin[2]) <= $signed(res.bmax[2])))
        else $error("result minimum above maximum");

    a_center_inside: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(res.ctr[0]) >= $signed(res.bmin[0]))
                  && ($signed(res.ctr[0]) <= $signed(res.bmax[0]))
                  && ($signed(res.ctr[1]) >= $signed(res.bmin[1]))
                  && ($signed(res.ctr[1]) <= $signed(res.bmax[1]))
                  && ($signed(res.ctr[2]) >= $signed(res.bmin[2]))
                  && ($signed(res.ctr[2]) <= $signed(res.bmax[2])))
        else $error("center outside the box");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid && !fin_ready |=> sum_valid && $stable(bounds))
        else $error("sum stage lost an item under backpressure");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_aabb_affine_transform_top.sv -----
`timescale 1ns / 100ps

import aabb_pkg::*;

class box_bounds_tracker;
    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    logic [CFG_W-1:0] matrix_regs [NUM_REGS];
    out_t             expected_bounds [$];
    int               mismatches;
    int               results_seen;

    function new();
        matrix_regs = '{64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000,
                        64'h0, 64'h0, 64'h0001_0000_0000_0000};
        mismatches   = 0;
        results_seen = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] word);
        if (idx < NUM_REGS)
            matrix_regs[idx] = word;
    endfunction

    function int pending();
        return expected_bounds.size();
    endfunction

    // upper half of a register is the even column
    function logic signed [63:0] entry(int r, int c);
        logic [CFG_W-1:0] pair;
        logic [31:0]      word;
        pair = matrix_regs[r * 2 + c / 2];
        word = (c % 2 == 1) ? pair[31:0] : pair[63:32];
        return {{32{word[31]}}, word};
    endfunction

    function logic signed [63:0] row_coord(int r, logic signed [63:0] p [3]);
        logic signed [63:0] acc;
        logic signed [63:0] prod;
        acc = entry(r, 3);
        for (int c = 0; c < 3; c++)
        begin
            prod = entry(r, c) * p[c];
            acc  = acc + (prod >>> FRAC_W);
        end
        if (acc > SAT_HI)
            return SAT_HI;
        if (acc < SAT_LO)
            return SAT_LO;
        return acc;
    endfunction

    function out_t predict_bounds(box_t b);
        logic signed [63:0] lo [3];
        logic signed [63:0] hi [3];
        logic signed [63:0] pt [3];
        logic signed [63:0] bmin [3];
        logic signed [63:0] bmax [3];
        logic signed [63:0] t;
        logic signed [63:0] ctr;
        logic signed [63:0] half;
        out_t               o;
        for (int a = 0; a < AXES; a++)
        begin
            lo[a]   = {{32{b.lo[a][31]}}, b.lo[a]};
            hi[a]   = {{32{b.hi[a][31]}}, b.hi[a]};
            bmin[a] = SAT_HI;
            bmax[a] = SAT_LO;
        end
        for (int k = 0; k < 8; k++)
        begin
            for (int a = 0; a < AXES; a++)
                pt[a] = ((k >> a) & 1) ? hi[a] : lo[a];
            for (int a = 0; a < AXES; a++)
            begin
                t = row_coord(a, pt);
                if (t < bmin[a])
                    bmin[a] = t;
                if (t > bmax[a])
                    bmax[a] = t;
            end
        end
        o.pad = '0;
        for (int a = 0; a < AXES; a++)
        begin
            ctr       = (bmax[a] + bmin[a]) >>> 1;
            half      = (bmax[a] - bmin[a]) >>> 1;
            o.bmin[a] = bmin[a][31:0];
            o.bmax[a] = bmax[a][31:0];
            o.ctr[a]  = ctr[31:0];
            o.half[a] = half[30:0];
        end
        return o;
    endfunction

    function void note_box(box_t b);
        expected_bounds.push_back(predict_bounds(b));
    endfunction

    task report_mismatch(string what);
        mismatches++;
        $display("%0t mismatch at result %0d: %s", $time, results_seen, what);
    endtask

    task compare_field(string name, int a, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s[%0d] got %h want %h", name, a, got, want));
    endtask

    task check_bounds(out_t got);
        out_t want;
        results_seen++;
        if (expected_bounds.size() == 0)
        begin
            report_mismatch("result with no box outstanding");
            return;
        end
        want = expected_bounds.pop_front();
        for (int a = 0; a < AXES; a++)
        begin
            compare_field("min", a, got.bmin[a], want.bmin[a]);
            compare_field("max", a, got.bmax[a], want.bmax[a]);
            compare_field("center", a, got.ctr[a], want.ctr[a]);
            compare_field("half_extent", a, {1'b0, got.half[a]}, {1'b0, want.half[a]});
        end
        if (got.pad !== '0)
            report_mismatch($sformatf("pad bits %b", got.pad));
    endtask
endclass

module tb_aabb_affine_transform_top;

    localparam int CLK_PERIOD = 20;
    localparam int RUN_LIMIT  = 10_000_000;
    localparam int PHASES     = 6;
    localparam int PHASE_LEN  = 250;
    localparam int LONG_HOLD  = 60;

    typedef enum {MAT_FULL, MAT_MODERATE, MAT_SPARSE} mat_style_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    box_bounds_tracker board;
    bit                tx_idle_on;
    bit                rx_idle_on;
    bit                hold_req;

    aabb_affine_transform_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // signed value in [-2^bits, 2^bits]
    function automatic logic [31:0] rand_span(int bits);
        return $urandom_range(0, 1 << (bits + 1)) - (1 << bits);
    endfunction

    function automatic logic [31:0] rand_coord(bit full);
        return full ? $urandom : rand_span(24);
    endfunction

    function automatic logic [31:0] rand_entry(mat_style_t style, bit is_offset);
        case (style)
            MAT_FULL:
                return $urandom;
            MAT_MODERATE:
                return is_offset ? rand_span(26) : rand_span(18);
            default:
                case ($urandom_range(0, 4))
                    0, 1: return 32'h0;
                    2: return 32'h0001_0000;
                    3: return 32'hFFFF_0000;
                    default: return is_offset ? rand_span(26) : rand_span(17);
                endcase
        endcase
    endfunction

    function automatic box_t make_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                                      logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
        box_t b;
        b.lo[0] = lx;
        b.lo[1] = ly;
        b.lo[2] = lz;
        b.hi[0] = hx;
        b.hi[1] = hy;
        b.hi[2] = hz;
        return b;
    endfunction

    task automatic send_box(input box_t b);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        board.note_box(b);
    endtask

    // wait for the pipeline to drain before touching the matrix
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_matrix(input logic [CFG_W-1:0] m [NUM_REGS], input bit with_bogus);
        int               last;
        logic [CFG_W-1:0] word;
        last = with_bogus ? NUM_REGS + 1 : NUM_REGS - 1;
        for (int i = 0; i <= last; i++)
        begin
            word = (i < NUM_REGS) ? m[i] : {$urandom, $urandom};
            cfg_we    <= 1'b1;
            cfg_index <= IDX_W'(i);
            cfg_data  <= word;
            @(posedge clk);
            board.set_reg(IDX_W'(i), word);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        box_t b;
        for (int k = 0; k < 8; k++)
        begin
            case (k)
                0: b = '0;
                1: b = make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
                2: b = make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
                3: b = make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
                // min above max
                4: b = make_box(32'h0005_0000, 32'h0006_0000, 32'h0007_0000,
                                32'hFFFD_0000, 32'hFFFE_0000, 32'hFFFF_0000);
                5: b = make_box(32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFD_0000,
                                32'h0004_0000, 32'h0005_0000, 32'h0006_0000);
                6: b = make_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
                default: b = make_box(COORD_MAX, COORD_MAX, COORD_MAX,
                                      COORD_MIN, COORD_MIN, COORD_MIN);
            endcase
            send_box(b);
        end
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
                board.check_bounds(out_t'(m_tdata));
            if (hold_req)
            begin
                stall_left = LONG_HOLD;
                hold_req   = 1'b0;
            end
            else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        box_t             b;
        logic [CFG_W-1:0] m [NUM_REGS];
        logic [31:0]      u;
        logic [31:0]      v;
        int               style;
        mat_style_t       phase_style [PHASES];
        phase_style = '{MAT_MODERATE, MAT_FULL, MAT_SPARSE, MAT_MODERATE, MAT_FULL, MAT_SPARSE};
        board      = new();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_req   = 1'b0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity from reset, then saturating matrices
        run_directed();
        settle();
        for (int i = 0; i < NUM_REGS; i++)
            m[i] = {COORD_MAX, COORD_MAX};
        load_matrix(m, 1'b1);
        run_directed();
        settle();
        for (int i = 0; i < NUM_REGS; i++)
            m[i] = {COORD_MIN, COORD_MIN};
        load_matrix(m, 1'b1);
        run_directed();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            for (int i = 0; i < NUM_REGS; i++)
                m[i] = {rand_entry(phase_style[ph], 1'b0), rand_entry(phase_style[ph], i % 2 == 1)};
            load_matrix(m, ph == 0 || $urandom_range(0, 1) == 1);
            if (ph == PHASES - 1)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (ph == 2)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                style = $urandom_range(0, 9);
                for (int a = 0; a < AXES; a++)
                begin
                    u = rand_coord(style < 3);
                    v = rand_coord(style < 3);
                    b.lo[a] = u;
                    b.hi[a] = v;
                    // mostly well-formed boxes
                    if (style >= 3 && style < 8 && $signed(u) > $signed(v))
                    begin
                        b.lo[a] = v;
                        b.hi[a] = u;
                    end
                end
                send_box(b);
            end
        end

        settle();
        if (board.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/aabb_pkg.sv
rtl/aabb_mul.sv
rtl/aabb_sel.sv
rtl/aabb_sum.sv
rtl/aabb_fin.sv
rtl/aabb_affine_transform_top.sv
tb/sv/tb_aabb_affine_transform_top.sv
